### rtl/lz77_pkg.sv
package lz77_pkg;

    typedef struct packed {
        logic       in_valid;
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        byte_taken;
        logic [2:0]  status;
        logic [31:0] total_size;
        logic [31:0] bytes_out;
    } out_item_t;

    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_BAD_DIST  = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    localparam logic [7:0] TYPE_10 = 8'h10;
    localparam logic [7:0] TYPE_11 = 8'h11;

endpackage

### rtl/lz77_ram.sv
module lz77_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lz77_type10_type11_decompressor.sv
// LZ77 type 0x10 / 0x11 stream decompressor.
// in:  one beat per tick (in_item_t). The beat carries in_valid, a compressed
//      byte and in_last; the tick itself is the item, and a tick whose
//      in_valid is 0 still yields one result.
// out: one beat per accepted tick (out_item_t): out_valid/out_byte give at
//      most one decompressed byte, byte_taken tells whether the offered byte
//      was consumed, plus status, declared size and running output count.
// Throughput: one tick per cycle while in_ready is high. Copies read the
//      8-bit history RAM (WINDOW_DEPTH entries, registered read); the read
//      for the next copy byte is issued ahead of its tick, and the byte
//      written by the previous tick is forwarded when the distance is one.
// Output: a tick's result is registered into the output register, or into
//      the one-deep skid register while the output is held; the skid keeps
//      ready high while a result waits; ready drops only when both are full.
// Reset: parser expects a type byte, counters clear. History needs no clear.
// Done and error states are sticky until reset.
module lz77_type10_type11_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lz77_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lz77_pkg::out_item_t  out_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        PH_TYPE, PH_SIZE, PH_FLAG, PH_ITEM, PH_COPY,
        PH_DONE, PH_ERR_TYPE, PH_ERR_DIST, PH_ERR_SHORT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        fmt11_reg, fmt11_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] prod_reg, prod_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  fleft_reg, fleft_next;
    logic [7:0]  tfirst_reg, tfirst_next;
    logic [15:0] tbytes_reg, tbytes_next;
    logic [1:0]  tcnt_reg, tcnt_next;
    logic [16:0] crem_reg, crem_next;
    logic [12:0] cdist_reg, cdist_next;
    logic        ended_reg, ended_next;

    // output skid: main register plus one spare
    lz77_pkg::out_item_t o_reg, o_next, s_reg;
    logic ov_reg, sv_reg;

    logic go;
    assign in_ready = !sv_reg;
    assign go = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data = o_reg;

    // history RAM; read for copy issued ahead of the copy tick
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic [7:0]    last_w_reg;
    logic          fwd_reg, fwd_next;

    lz77_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [7:0] copy_byte;
    assign copy_byte = fwd_reg ? last_w_reg : rdata;

    logic [31:0] room;
    logic [16:0] len;
    logic [12:0] tok_dist;
    logic        start;
    logic [31:0] prod_inc;
    logic [1:0]  need;
    logic [7:0]  b;
    logic [7:0]  tb1, tb2, tb3;

    assign b = in_data.in_byte;
    assign prod_inc = prod_reg + 32'd1;
    assign room = size_reg - prod_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        fmt11_next  = fmt11_reg;
        hcnt_next   = hcnt_reg;
        size_next   = size_reg;
        prod_next   = prod_reg;
        flag_next   = flag_reg;
        fleft_next  = fleft_reg;
        tfirst_next = tfirst_reg;
        tbytes_next = tbytes_reg;
        tcnt_next   = tcnt_reg;
        crem_next   = crem_reg;
        cdist_next  = cdist_reg;
        ended_next  = ended_reg;
        we = 1'b0;
        wdata = '0;
        o_next = '0;
        start = 1'b0;
        len = '0;
        tok_dist = '0;
        need = 2'd2;
        tb1 = '0;
        tb2 = '0;
        tb3 = '0;

        if (go)
        begin
            if (phase_reg == PH_COPY)
            begin
                we = 1'b1;
                wdata = copy_byte;
                o_next.out_valid = 1'b1;
                o_next.out_byte = copy_byte;
                prod_next = prod_inc;
                crem_next = crem_reg - 17'd1;
                if (crem_reg == 17'd1)
                begin
                    if (prod_inc >= size_reg)
                        phase_next = PH_DONE;
                    else if (fleft_reg == 4'd0)
                        phase_next = PH_FLAG;
                    else
                        phase_next = PH_ITEM;
                end
            end
            else if (in_data.in_valid && (phase_reg == PH_TYPE || phase_reg == PH_SIZE
                     || phase_reg == PH_FLAG || phase_reg == PH_ITEM))
            begin
                o_next.byte_taken = 1'b1;
                if (in_data.in_last)
                    ended_next = 1'b1;
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (b == lz77_pkg::TYPE_10 || b == lz77_pkg::TYPE_11)
                        begin
                            fmt11_next = (b == lz77_pkg::TYPE_11);
                            hcnt_next = '0;
                            size_next = '0;
                            phase_next = PH_SIZE;
                        end
                        else
                            phase_next = PH_ERR_TYPE;
                    end
                    PH_SIZE:
                    begin
                        case ((hcnt_reg < 3'd3) ? hcnt_reg[1:0] : 2'(hcnt_reg - 3'd3))
                            2'd0: size_next = size_reg | {24'd0, b};
                            2'd1: size_next = size_reg | {16'd0, b, 8'd0};
                            2'd2: size_next = size_reg | {8'd0, b, 16'd0};
                            default: size_next = size_reg | {b, 24'd0};
                        endcase
                        hcnt_next = hcnt_reg + 3'd1;
                        if ((hcnt_next == 3'd3 && !(fmt11_reg && size_next == 32'd0))
                            || hcnt_next == 3'd7)
                            phase_next = (size_next == 32'd0) ? PH_DONE : PH_FLAG;
                    end
                    PH_FLAG:
                    begin
                        flag_next = b;
                        fleft_next = 4'd8;
                        tcnt_next = '0;
                        phase_next = PH_ITEM;
                    end
                    default:
                    begin
                        if (tcnt_reg == 2'd0 && !flag_reg[7])
                        begin
                            we = 1'b1;
                            wdata = b;
                            o_next.out_valid = 1'b1;
                            o_next.out_byte = b;
                            prod_next = prod_inc;
                            flag_next = {flag_reg[6:0], 1'b0};
                            fleft_next = fleft_reg - 4'd1;
                            if (prod_inc >= size_reg)
                                phase_next = PH_DONE;
                            else if (fleft_next == 4'd0)
                                phase_next = PH_FLAG;
                        end
                        else
                        begin
                            if (tcnt_reg == 2'd0)
                            begin
                                tfirst_next = b;
                                tbytes_next = '0;
                            end
                            tcnt_next = tcnt_reg + 2'd1;
                            if (!fmt11_reg || tfirst_next[7:5] != 3'd0)
                                need = 2'd2;
                            else if (tfirst_next[4])
                                need = 2'd0;
                            else
                                need = 2'd3;
                            tb1 = (tcnt_reg == 2'd1) ? b : tbytes_reg[15:8];
                            tb1 = (tcnt_reg == 2'd3) ? tbytes_reg[15:8] : tb1;
                            if (tcnt_reg != 2'd0)
                                tbytes_next = {tbytes_reg[7:0], b};
                            if (need == 2'd2 && tcnt_reg == 2'd1)
                            begin
                                start = 1'b1;
                                len = 17'(tfirst_reg[7:4]) + (fmt11_reg ? 17'd1 : 17'd3);
                                tok_dist = {1'b0, tfirst_reg[3:0], b} + 13'd1;
                            end
                            else if (need == 2'd3 && tcnt_reg == 2'd2)
                            begin
                                tb1 = tbytes_reg[7:0];
                                start = 1'b1;
                                len = 17'({tfirst_reg[3:0], tb1[7:4]}) + 17'd17;
                                tok_dist = {1'b0, tb1[3:0], b} + 13'd1;
                            end
                            else if (need == 2'd0 && tcnt_reg == 2'd3)
                            begin
                                tb1 = tbytes_reg[15:8];
                                tb2 = tbytes_reg[7:0];
                                tb3 = b;
                                start = 1'b1;
                                len = {1'b0, tfirst_reg[3:0], tb1, tb2[7:4]} + 17'd273;
                                tok_dist = {1'b0, tb2[3:0], tb3} + 13'd1;
                            end
                            if (start)
                            begin
                                flag_next = {flag_reg[6:0], 1'b0};
                                if (fleft_reg != 4'd0)
                                    fleft_next = fleft_reg - 4'd1;
                                tcnt_next = '0;
                                if (32'(tok_dist) > prod_reg)
                                    phase_next = PH_ERR_DIST;
                                else
                                begin
                                    crem_next = (32'(len) < room) ? len : room[16:0];
                                    cdist_next = tok_dist;
                                    phase_next = PH_COPY;
                                end
                            end
                        end
                    end
                endcase
            end
            if (ended_next && (phase_next == PH_SIZE || phase_next == PH_FLAG
                || phase_next == PH_ITEM))
                phase_next = PH_ERR_SHORT;
            case (phase_next)
                PH_DONE:      o_next.status = lz77_pkg::ST_DONE;
                PH_ERR_TYPE:  o_next.status = lz77_pkg::ST_BAD_TYPE;
                PH_ERR_DIST:  o_next.status = lz77_pkg::ST_BAD_DIST;
                PH_ERR_SHORT: o_next.status = lz77_pkg::ST_SHORT;
                default:      o_next.status = lz77_pkg::ST_RUN;
            endcase
            o_next.total_size = size_next;
            o_next.bytes_out = prod_next;
        end
    end

    // read address for the byte the next copy tick needs
    logic [31:0] src_full;
    logic        use_next;
    assign use_next = (phase_next == PH_COPY);
    assign src_full = prod_next - 32'(use_next ? cdist_next : cdist_reg);
    assign raddr = go ? src_full[AW-1:0] : (prod_reg[AW-1:0] - AW'(cdist_reg));
    assign waddr = prod_reg[AW-1:0];
    assign fwd_next = go ? (we && src_full[AW-1:0] == waddr) : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            fmt11_reg <= 1'b0;
            hcnt_reg <= '0;
            size_reg <= '0;
            prod_reg <= '0;
            flag_reg <= '0;
            fleft_reg <= '0;
            tfirst_reg <= '0;
            tbytes_reg <= '0;
            tcnt_reg <= '0;
            crem_reg <= '0;
            cdist_reg <= '0;
            ended_reg <= 1'b0;
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fmt11_reg <= fmt11_next;
            hcnt_reg <= hcnt_next;
            size_reg <= size_next;
            prod_reg <= prod_next;
            flag_reg <= flag_next;
            fleft_reg <= fleft_next;
            tfirst_reg <= tfirst_next;
            tbytes_reg <= tbytes_next;
            tcnt_reg <= tcnt_next;
            crem_reg <= crem_next;
            cdist_reg <= cdist_next;
            ended_reg <= ended_next;
            fwd_reg <= fwd_next;
            if (!ov_reg || out_ready)
            begin
                ov_reg <= sv_reg || go;
                sv_reg <= 1'b0;
            end
            else if (go)
            begin
                sv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            last_w_reg <= wdata;
        if (!ov_reg || out_ready)
            o_reg <= sv_reg ? s_reg : o_next;
        else if (go)
            s_reg <= o_next;
    end

    // hold the read when no tick moves so rdata stays current
    // (raddr recomputed from held state gives the same entry)

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg && ov_reg && !out_ready) |=> sv_reg)
        else $error("skid entry lost");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid full with empty output");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !we) |=> $stable(prod_reg))
        else $error("count moved without write");
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("done not sticky");

endmodule
